// ----- src/rac_pkg.sv -----
// ----------------------------------------------------------------------------
// rac_pkg: readout artifact check shared definitions
// Sizes, register indexes, format codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 16;

    localparam int PIX_W      = 16;
    localparam int FMT_W      = 2;
    localparam int SIZE_W     = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int SUM_W      = 40;
    localparam int SQ_W       = 56;
    localparam int N_W        = 25;
    localparam int PROD_W     = 90;
    localparam int MUL_STEPS  = SQ_W;
    localparam int CNT_W      = $clog2(MUL_STEPS);

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // pixel format codes
    localparam logic [FMT_W-1:0] FMT_COLUMN = 2'd0;
    localparam logic [FMT_W-1:0] FMT_GAIN   = 2'd1;

    typedef struct packed {
        logic take;      // capture pixel, read column bit
        logic update;    // column bit write, sums, indices
        logic nprod;     // pixel count n = w*h
        logic scale;     // 400*n and 401*sum operands
        logic mul_step;  // one shift-add step of both products
        logic load;      // result into output register
    } t_cmd;

    typedef struct packed {
        logic frame_end; // pixel in update is the last of the frame
        logic gain_mode; // gain check selected
        logic slot_free; // output register can take a result
    } t_status;

endpackage

// ----- src/rac_if.sv -----
// ----------------------------------------------------------------------------
// rac_if: readout artifact check channel interfaces
// Pixel stream, result stream and register write channel.
// ----------------------------------------------------------------------------
interface rac_pix_if;
    import rac_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface rac_res_if;
    logic valid;
    logic ready;
    logic dropped_columns;
    logic nonuniform_gain;
    modport source (output valid, output dropped_columns, output nonuniform_gain,
                    input ready);
    modport sink   (input valid, input dropped_columns, input nonuniform_gain,
                    output ready);
endinterface

interface rac_cfg_if;
    import rac_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/rac_ctrl.sv -----
// ----------------------------------------------------------------------------
// rac_ctrl: readout artifact check controller
// Sequences pixel update, end-of-frame multiply and result hand-off.
// ----------------------------------------------------------------------------
module rac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pix_valid,
    output logic             o_pix_ready,
    input  rac_pkg::t_status i_status,
    output rac_pkg::t_cmd    o_cmd
);
    import rac_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_NPROD,
        S_SCALE,
        S_MUL,
        S_FIN
    } t_state;

    t_state           r_state;
    logic             r_ready;
    logic [CNT_W-1:0] r_cnt;

    assign o_pix_ready = r_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.take     = r_ready & i_pix_valid;
        o_cmd.update   = (r_state == S_UPD);
        o_cmd.nprod    = (r_state == S_NPROD);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.mul_step = (r_state == S_MUL);
        o_cmd.load     = (r_state == S_FIN) & i_status.slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_ready && i_pix_valid) begin
                        r_state <= S_UPD;
                        r_ready <= 1'b0;
                    end
                end
                S_UPD: begin
                    if (i_status.frame_end) begin
                        r_state <= i_status.gain_mode ? S_NPROD : S_FIN;
                    end else begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                S_NPROD: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_MUL;
                    r_cnt   <= '0;
                end
                S_MUL: begin
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (i_status.slot_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- src/rac_dpath.sv -----
// ----------------------------------------------------------------------------
// rac_dpath: readout artifact check datapath
// Registers, column memory, sums, bit-serial products, output register.
// ----------------------------------------------------------------------------
module rac_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rac_pkg::t_cmd                  i_cmd,
    output rac_pkg::t_status               o_status,
    input  logic [rac_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_cfg_valid,
    input  logic [rac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_res_ready,
    output logic                           o_res_valid,
    output logic                           o_dropped,
    output logic                           o_gain
);
    import rac_pkg::*;

    // configuration
    logic [FMT_W-1:0]  r_fmt;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    // frame state
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_dropped;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sqsum;

    // captured item
    logic [PIX_W-1:0]  r_pix;
    logic [COL_W-1:0]  r_colc;
    logic [ROW_W-1:0]  r_rowc;
    logic              r_seen_q;

    logic              col_mem [MAX_WIDTH];

    // end of frame
    logic              r_res_drop;
    logic              r_gain_en;
    logic [N_W-1:0]    r_n;
    logic [PROD_W-1:0] r_al, r_ar, r_accl, r_accr;
    logic [SQ_W-1:0]   r_bl, r_br;

    logic              r_out_valid;
    logic              r_out_drop;
    logic              r_out_gain;

    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic              nz, seen, last_col, last_row, drop_now;
    logic [2*PIX_W-1:0] sq;
    logic [SUM_W-1:0]  n_sum;
    logic [SQ_W-1:0]   n_sqsum;

    // zero reads as one, large values saturate
    assign w_eff = (r_width == '0) ? SIZE_W'(1) :
                   (r_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : r_width;
    assign h_eff = (r_height == '0) ? SIZE_W'(1) :
                   (r_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : r_height;

    // stale index past a shrunk geometry maps to the last column or row
    assign col_c = ({1'b0, r_col} < w_eff) ? r_col : COL_W'(w_eff - 1'b1);
    assign row_c = ({1'b0, r_row} < h_eff) ? r_row : ROW_W'(h_eff - 1'b1);

    assign nz       = (r_pix != '0);
    assign seen     = (r_rowc == '0) ? nz : (r_seen_q | nz);
    assign last_col = ({1'b0, r_colc} == SIZE_W'(w_eff - 1'b1));
    assign last_row = ({1'b0, r_rowc} == SIZE_W'(h_eff - 1'b1));
    assign drop_now = r_dropped | (last_row & ~seen);
    assign sq       = r_pix * r_pix;
    assign n_sum    = r_sum + SUM_W'(r_pix);
    assign n_sqsum  = r_sqsum + SQ_W'(sq);

    assign o_status.frame_end = last_col & last_row;
    assign o_status.gain_mode = (r_fmt == FMT_GAIN);
    assign o_status.slot_free = ~r_out_valid | i_res_ready;

    assign o_res_valid = r_out_valid;
    assign o_dropped   = r_out_drop;
    assign o_gain      = r_out_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_COLUMN;
            r_width  <= SIZE_W'(1);
            r_height <= SIZE_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PIXEL_FORMAT: r_fmt    <= i_cfg_data[FMT_W-1:0];
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // column memory: read at capture, write back during update
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_seen_q <= col_mem[col_c];
        end
        if (i_cmd.update) begin
            col_mem[r_colc] <= seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix  <= i_pixel & PIX_MASK;
            r_colc <= col_c;
            r_rowc <= row_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_dropped <= 1'b0;
            r_sum     <= '0;
            r_sqsum   <= '0;
        end else if (i_cmd.update) begin
            if (last_col && last_row) begin
                r_col     <= '0;
                r_row     <= '0;
                r_dropped <= 1'b0;
                r_sum     <= '0;
                r_sqsum   <= '0;
            end else if (last_col) begin
                r_col     <= '0;
                r_row     <= r_rowc + 1'b1;
                r_dropped <= drop_now;
                r_sum     <= n_sum;
                r_sqsum   <= n_sqsum;
            end else begin
                r_col     <= r_colc + 1'b1;
                r_row     <= r_rowc;
                r_dropped <= drop_now;
                r_sum     <= n_sum;
                r_sqsum   <= n_sqsum;
            end
        end
    end

    // 400*n*sumsq vs 401*sum*sum, both products shift-add, one bit a step
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && last_col && last_row) begin
            r_res_drop <= (r_fmt == FMT_COLUMN) & drop_now;
            r_gain_en  <= (r_fmt == FMT_GAIN);
            r_bl       <= n_sqsum;
            r_br       <= SQ_W'(n_sum);
        end
        if (i_cmd.nprod) begin
            r_n <= N_W'(w_eff) * N_W'(h_eff);
        end
        if (i_cmd.scale) begin
            r_al   <= (PROD_W'(r_n) << 8) + (PROD_W'(r_n) << 7) + (PROD_W'(r_n) << 4);
            r_ar   <= (PROD_W'(r_br[SUM_W-1:0]) << 8) + (PROD_W'(r_br[SUM_W-1:0]) << 7)
                    + (PROD_W'(r_br[SUM_W-1:0]) << 4) + PROD_W'(r_br[SUM_W-1:0]);
            r_accl <= '0;
            r_accr <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_bl[0]) begin
                r_accl <= r_accl + r_al;
            end
            if (r_br[0]) begin
                r_accr <= r_accr + r_ar;
            end
            r_al <= r_al << 1;
            r_ar <= r_ar << 1;
            r_bl <= r_bl >> 1;
            r_br <= r_br >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_drop <= r_res_drop;
            r_out_gain <= r_gain_en & (r_accl > r_accr);
        end
    end

endmodule

// ----- src/readout_artifact_check_top.sv -----
// ----------------------------------------------------------------------------
// readout_artifact_check_top: detector readout artifact check
// Dropped-column and gain-uniformity checks over one raster frame.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake       Payload
//  i_pix    in   valid/ready     pixel[15:0], raster order
//  o_res    out  valid/ready     dropped_columns, nonuniform_gain
//  i_cfg    in   valid/ready     index[1:0], data[12:0]; ready always high
//
//  Per pixel: capture + column-bit read, then update/write back of
//  the single-port column memory. The last pixel of a frame adds a result load,
//  and in gain mode also pixel count, operand scaling and a 56-step bit-serial
//  shift-add over both 90-bit products.
//  Reset: synchronous, active low; clears indices, sums, flags and registers.
//  The column memory has no reset; row 0 of each frame writes every bit of its width.
//  Stalls: the result sits in an output register, so pixels of the next frame
//  keep flowing while it waits; only a second result waits for the slot.
//
module readout_artifact_check_top (
    input logic i_clk,
    input logic i_rst_n,
    rac_pix_if.sink   i_pix,
    rac_res_if.source o_res,
    rac_cfg_if.sink   i_cfg
);
    import rac_pkg::*;

    t_cmd    cmd;
    t_status status;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    rac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .o_pix_ready (i_pix.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rac_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_pixel     (i_pix.pixel),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_dropped   (o_res.dropped_columns),
        .o_gain      (o_res.nonuniform_gain)
    );

endmodule

// ----- src/rac_checker.sv -----
// ----------------------------------------------------------------------------
// rac_checker: readout artifact check port assertions
// Watches the top-level channels; bound to the top level below.
// ----------------------------------------------------------------------------
module rac_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_pix_valid,
    input logic i_pix_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_drop,
    input logic i_res_gain
);

    // one pixel at a time: ready drops after each transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready |=> !i_pix_ready)
        else $error("pixel ready stayed high after a transaction");

    // the two checks belong to different formats
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_res_drop && i_res_gain))
        else $error("both result flags set");

    // a result is loaded only while the input side is held off
    a_result_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_pix_ready))
        else $error("result appeared while pixels were being taken");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_drop) && $stable(i_res_gain))
        else $error("stalled result changed");

endmodule

bind readout_artifact_check_top rac_checker u_rac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_drop  (o_res.dropped_columns),
    .i_res_gain  (o_res.nonuniform_gain)
);

// ----- sim/readout_artifact_check_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// readout_artifact_check_top_tb: self-checking bench for the readout check
// Streams raster frames through the pixel channel under random idling and a
// long result back-pressure window. Every accepted pixel runs through a local
// model of the column and gain checks; end-of-frame flags are compared in
// order with what the block returns.
// ----------------------------------------------------------------------------
module readout_artifact_check_top_tb;
    import rac_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PCT      = 28;
    localparam int HOLD_CYCLES   = 400;   // long result stall, fills the output slot
    localparam int SETTLE_CYCLES = 80;    // covers the worst frame end, in gain mode
    localparam int STALL_LIMIT   = 5000;  // cycles with no transaction at all
    localparam int RANDOM_PIXELS = 350;
    localparam int RANDOM_FRAMES = 24;
    localparam int SHOW_LIMIT    = 10;

    // index 3 maps to no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
    // formats with no check
    localparam logic [FMT_W-1:0]     FMT_NONE     = 2'd2;
    localparam logic [FMT_W-1:0]     FMT_NONE_ALT = 2'd3;

    typedef struct packed {
        logic dropped_columns;
        logic nonuniform_gain;
    } t_flags;

    logic i_clk;
    logic i_rst_n;

    rac_pix_if pix_if ();
    rac_res_if res_if ();
    rac_cfg_if cfg_if ();

    readout_artifact_check_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // ------------------------------------------------------------------------
    // Frame model state: register copies, column history, running sums
    // ------------------------------------------------------------------------
    logic [FMT_W-1:0]  cur_format;
    logic [SIZE_W-1:0] cur_width;
    logic [SIZE_W-1:0] cur_height;
    bit                col_nonzero [MAX_WIDTH];
    int unsigned       col_pos;
    int unsigned       row_pos;
    bit                drop_pending;
    logic [63:0]       pix_sum;
    logic [63:0]       pix_sq_sum;
    t_flags            flags_due [$];     // frame results still owed by the block

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0]  pixel_backlog [$]; // pixels waiting for the driver
    int unsigned       pixels_queued;
    int unsigned       pixels_taken;
    bit                pix_sent;          // pixel transaction at the last rising edge
    bit                calm;              // no idling on either side while set
    int unsigned       holds_asked;
    int unsigned       holds_served;
    int unsigned       hold_left;
    int unsigned       stall_cycles;
    int unsigned       fail_count;
    int unsigned       shown;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Zero is read as one, anything above the maximum saturates.
    function automatic int unsigned fit_size(input logic [SIZE_W-1:0] v,
                                             input int unsigned limit);
        if (v == '0) return 1;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    // Advance the frame model by one pixel; at the last pixel of the frame
    // the expected flags are queued and the frame state clears.
    function automatic void track_pixel(input logic [PIX_W-1:0] pix);
        int unsigned  w;
        int unsigned  h;
        int unsigned  col;
        int unsigned  row;
        logic [63:0]  p;
        bit           seen;
        logic [127:0] lhs;
        logic [127:0] rhs;
        t_flags       f;
        w   = fit_size(cur_width, MAX_WIDTH);
        h   = fit_size(cur_height, MAX_HEIGHT);
        // a position left over from a larger geometry folds onto the last one
        col = (col_pos < w) ? col_pos : w - 1;
        row = (row_pos < h) ? row_pos : h - 1;
        p   = 64'(pix & PIX_MASK);
        // row 0 starts each column fresh, later rows OR into the history
        seen = (p != 0) || (row != 0 && col_nonzero[col]);
        col_nonzero[col] = seen;
        if (row == h - 1 && !seen) drop_pending = 1'b1;
        pix_sum    += p;
        pix_sq_sum += p * p;
        if (col != w - 1) begin
            col_pos = col + 1;
            row_pos = row;
            return;
        end
        if (row != h - 1) begin
            col_pos = 0;
            row_pos = row + 1;
            return;
        end
        // variance > (5% of mean)^2  <=>  400*n*sumsq > 401*sum^2, exact
        lhs = 128'(400) * 128'(w * h) * 128'(pix_sq_sum);
        rhs = 128'(401) * 128'(pix_sum) * 128'(pix_sum);
        f.dropped_columns = (cur_format == FMT_COLUMN) && drop_pending;
        f.nonuniform_gain = (cur_format == FMT_GAIN) && (lhs > rhs);
        flags_due.push_back(f);
        col_pos      = 0;
        row_pos      = 0;
        drop_pending = 1'b0;
        pix_sum      = '0;
        pix_sq_sum   = '0;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel driver: a new pixel goes out on the falling edge once the last
    // one was taken; random gaps unless the calm stretch is on.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!pix_if.valid || pix_sent) begin
            if (pixel_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                pix_if.valid <= 1'b1;
                pix_if.pixel <= pixel_backlog.pop_front();
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result ready: random stalls, plus a long hold-off on request so that
    // the output slot fills and the pixel input backs up.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (holds_served != holds_asked) begin
            res_if.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            holds_served++;
        end else begin
            res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every transaction on the rising edge. Register writes and
    // pixels feed the model in one process, so their order is kept; results
    // are checked against the oldest owed frame.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_flags got;
        t_flags want;
        bit     res_taken;
        bit     cfg_taken;
        if (!i_rst_n) begin
            pix_sent     = 1'b0;
            stall_cycles = 0;
            cur_format   = FMT_COLUMN;
            cur_width    = SIZE_W'(1);
            cur_height   = SIZE_W'(1);
            col_pos      = 0;
            row_pos      = 0;
            drop_pending = 1'b0;
            pix_sum      = '0;
            pix_sq_sum   = '0;
        end else begin
            pix_sent  = pix_if.valid && pix_if.ready;
            res_taken = res_if.valid && res_if.ready;
            cfg_taken = cfg_if.valid && cfg_if.ready;
            if (cfg_taken) begin
                case (cfg_if.index)
                    REG_PIXEL_FORMAT: cur_format = cfg_if.data[FMT_W-1:0];
                    REG_IMAGE_WIDTH:  cur_width  = cfg_if.data[SIZE_W-1:0];
                    REG_IMAGE_HEIGHT: cur_height = cfg_if.data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (pix_sent) begin
                track_pixel(pix_if.pixel);
                pixels_taken++;
            end
            if (res_taken) begin
                got.dropped_columns = res_if.dropped_columns;
                got.nonuniform_gain = res_if.nonuniform_gain;
                if (flags_due.size() == 0) begin
                    fail_count++;
                    if (shown < SHOW_LIMIT)
                        $display("unexpected result: dropped_columns %0b nonuniform_gain %0b",
                                 got.dropped_columns, got.nonuniform_gain);
                    shown++;
                end else begin
                    want = flags_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (shown < SHOW_LIMIT)
                            $display("flag mismatch: dropped_columns exp %0b got %0b, %s %0b got %0b",
                                     want.dropped_columns, got.dropped_columns,
                                     "nonuniform_gain exp", want.nonuniform_gain,
                                     got.nonuniform_gain);
                        shown++;
                    end
                end
            end
            if (pix_sent || res_taken || cfg_taken) stall_cycles = 0;
            else stall_cycles++;
        end
    end

    // Watchdog: a run that stops moving is a failure.
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_pixel(input logic [PIX_W-1:0] v);
        pixel_backlog.push_back(v);
        pixels_queued++;
    endtask

    // Random frame content. zero_pct sets the share of zero pixels (drives
    // the dropped-column outcome); flat draws values close to one level so
    // the gain test lands on both sides of its threshold.
    task automatic queue_frame(input int unsigned count, input int zero_pct, input bit flat);
        int base;
        int spread;
        int v;
        base   = $urandom_range(65000, 200);
        spread = base * int'($urandom_range(150, 0)) / 1000;
        for (int unsigned i = 0; i < count; i++) begin
            if (int'($urandom_range(99)) < zero_pct) v = 0;
            else if (flat) v = base - spread + int'($urandom_range(2 * spread, 0));
            else v = $urandom_range(65535, 0);
            if (v > 65535) v = 65535;
            push_pixel(PIX_W'(v));
        end
    endtask

    // Register write; valid stays up across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] fmt,
                              input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait until every queued pixel is in and every owed frame is out, then
    // give the block time to finish a frame end that owes nothing yet.
    task automatic wait_idle();
        while (pixels_taken != pixels_queued || flags_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned      w;
        int unsigned      h;
        int unsigned      frames;
        int unsigned      rnd_pixels;
        int unsigned      rnd_frames;
        int               zero_pct;
        logic [FMT_W-1:0] fmt;

        // every block input known from time zero
        i_rst_n       = 1'b0;
        pix_if.valid  = 1'b0;
        pix_if.pixel  = '0;
        res_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_PIXEL_FORMAT;
        cfg_if.data   = '0;
        calm          = 1'b0;
        pixels_queued = 0;
        pixels_taken  = 0;
        holds_asked   = 0;
        holds_served  = 0;
        hold_left     = 0;
        stall_cycles  = 0;
        fail_count    = 0;
        shown         = 0;
        rnd_pixels    = 0;
        rnd_frames    = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: column check on 1x1 frames, zero then full scale
        push_pixel(16'h0000);
        push_pixel(16'hFFFF);
        wait_idle();

        // zero width and height read as one; single pixel and all-zero
        // frames never flag gain
        set_config(CFG_DATA_W'(FMT_GAIN), '0, '0);
        push_pixel(16'h0000);
        push_pixel(16'd12345);
        wait_idle();

        // no-check formats, the second one with the upper data bits set
        set_config(CFG_DATA_W'(FMT_NONE), 13'd2, 13'd2);
        push_pixel(16'h0000);
        push_pixel(16'h0000);
        push_pixel(16'h0009);
        push_pixel(16'h0000);
        wait_idle();
        set_config({11'h7FF, FMT_NONE_ALT}, 13'd3, 13'd1);
        push_pixel(16'h0000);
        push_pixel(16'h0000);
        push_pixel(16'h0000);
        wait_idle();

        // 3x2, middle column zero in both rows
        set_config(CFG_DATA_W'(FMT_COLUMN), 13'd3, 13'd2);
        push_pixel(16'd5);
        push_pixel(16'd0);
        push_pixel(16'd0);
        push_pixel(16'd0);
        push_pixel(16'd0);
        push_pixel(16'd7);
        wait_idle();

        // flat row passes the gain test, alternating extremes fail it
        set_config(CFG_DATA_W'(FMT_GAIN), 13'd4, 13'd1);
        repeat (4) push_pixel(16'd1000);
        push_pixel(16'h0000);
        push_pixel(16'hFFFF);
        push_pixel(16'h0000);
        push_pixel(16'hFFFF);
        wait_idle();

        // format only counts at the last pixel: switch it halfway
        set_config(CFG_DATA_W'(FMT_COLUMN), 13'd4, 13'd3);
        queue_frame(6, 30, 1'b0);
        wait_idle();
        set_config(CFG_DATA_W'(FMT_GAIN), 13'd4, 13'd3);
        queue_frame(6, 0, 1'b1);
        wait_idle();

        // geometry shrinks inside row 3 of a 6x5 frame; the stale position
        // folds onto the last pixel of the new 3x2 frame
        set_config(CFG_DATA_W'(FMT_GAIN), 13'd6, 13'd5);
        queue_frame(22, 30, 1'b0);
        wait_idle();
        set_config(CFG_DATA_W'(FMT_COLUMN), 13'd3, 13'd2);
        push_pixel(16'h0000);
        wait_idle();

        // back-pressure: 1x1 frames while the result side holds off
        set_config(CFG_DATA_W'(FMT_COLUMN), 13'd1, 13'd1);
        holds_asked++;
        queue_frame(40, 50, 1'b0);
        wait_idle();

        // random phases of small frames, a stretch of them with no idling
        while (rnd_pixels < RANDOM_PIXELS || rnd_frames < RANDOM_FRAMES) begin
            calm = (rnd_frames >= 8 && rnd_frames < 16);
            case ($urandom_range(9))
                0, 1, 2, 3: fmt = FMT_COLUMN;
                4, 5, 6, 7: fmt = FMT_GAIN;
                8:          fmt = FMT_NONE;
                default:    fmt = FMT_NONE_ALT;
            endcase
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 0) : $urandom_range(8, 1);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
            frames = $urandom_range(4, 1);
            set_config(CFG_DATA_W'(fmt), CFG_DATA_W'(w), CFG_DATA_W'(h));
            for (int unsigned f = 0; f < frames; f++) begin
                case ($urandom_range(4))
                    0, 1:    zero_pct = 0;
                    2:       zero_pct = 30;
                    3:       zero_pct = 70;
                    default: zero_pct = 95;
                endcase
                queue_frame(fit_size(SIZE_W'(w), MAX_WIDTH) * fit_size(SIZE_W'(h), MAX_HEIGHT),
                            zero_pct, $urandom_range(1));
                rnd_pixels += fit_size(SIZE_W'(w), MAX_WIDTH) *
                              fit_size(SIZE_W'(h), MAX_HEIGHT);
            end
            rnd_frames += frames;
            wait_idle();
        end
        calm = 1'b0;

        wait_idle();
        if (fail_count == 0 && flags_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
